// ----- rtl/rdwbc_pkg.sv -----
// package for the ramped dry/wet bypass crossfade unit
// request and result types, lane control struct, register map, ramp function
// no dependencies
package rdwbc_pkg;

    localparam int MAX_DELAY = 256;
    localparam int DELAY_AW  = $clog2(MAX_DELAY);
    localparam int LEN_W     = 9;
    localparam int MIX_W     = 17;
    localparam int SAMPLE_W  = 24;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [MIX_W-1:0] UNITY = MIX_W'(65536);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DELAY);

    localparam logic [2:0] REG_INPUT_CHANNELS   = 3'd0;
    localparam logic [2:0] REG_OUTPUT_CHANNELS  = 3'd1;
    localparam logic [2:0] REG_DRY_DELAY_LENGTH = 3'd2;
    localparam logic [2:0] REG_SWITCH_RAMP_STEP = 3'd3;
    localparam logic [2:0] REG_BYPASS_RAMP_STEP = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_left;
        logic signed [SAMPLE_W-1:0] in_right;
        logic signed [SAMPLE_W-1:0] wet_sample;
        logic                       switch_on;
        logic                       bypass_on;
    } rdwbc_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_left;
        logic signed [SAMPLE_W-1:0] out_right;
        logic signed [SAMPLE_W-1:0] mono_feed;
    } rdwbc_out_t;

    typedef struct packed {
        logic accept;
        logic gain;
        logic mul;
    } rdwbc_ctl_t;

    function automatic logic [MIX_W-1:0] ramp(input logic [MIX_W-1:0] v,
                                              input logic             on,
                                              input logic [MIX_W-1:0] step);
        logic [MIX_W-1:0] target;
        logic [MIX_W-1:0] res;
        target = on ? UNITY : '0;
        res    = v;
        if (v < target)
        begin
            res = ((target - v) > step) ? MIX_W'(v + step) : target;
        end
        else if (v > target)
        begin
            res = ((v - target) > step) ? MIX_W'(v - step) : target;
        end
        return res;
    endfunction

endpackage

// ----- rtl/rdwbc_gain.sv -----
// mix level ramps and wet gain multiply
// depends on rdwbc_pkg
module rdwbc_gain (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rdwbc_pkg::rdwbc_ctl_t       ctl,
    input  logic                        switch_on,
    input  logic                        bypass_on,
    input  logic [rdwbc_pkg::MIX_W-1:0] switch_step,
    input  logic [rdwbc_pkg::MIX_W-1:0] bypass_step,
    output logic [rdwbc_pkg::MIX_W-1:0] gain
);
    import rdwbc_pkg::*;

    logic [MIX_W-1:0]   switch_mix_reg;
    logic [MIX_W-1:0]   bypass_mix_reg;
    logic [MIX_W-1:0]   gain_reg;
    logic [2*MIX_W-1:0] gain_prod;

    assign gain_prod = switch_mix_reg * (UNITY - bypass_mix_reg);
    assign gain      = gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            switch_mix_reg <= '0;
            bypass_mix_reg <= UNITY;
        end
        else if (ctl.accept)
        begin
            switch_mix_reg <= ramp(switch_mix_reg, switch_on, switch_step);
            bypass_mix_reg <= ramp(bypass_mix_reg, bypass_on, bypass_step);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.gain)
        begin
            gain_reg <= gain_prod[MIX_W+15:16];
        end
    end

`ifndef SYNTHESIS
    a_switch_mix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        switch_mix_reg <= UNITY)
        else $error("switch mix above unity");
    a_bypass_mix_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bypass_mix_reg <= UNITY)
        else $error("bypass mix above unity");
    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(ctl.gain) |-> gain_reg <= UNITY)
        else $error("wet gain above unity");
`endif

endmodule

// ----- rtl/rdwbc_lane.sv -----
// one channel lane: dry delay line and gain blend
// depends on rdwbc_pkg
module rdwbc_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rdwbc_pkg::rdwbc_ctl_t                 ctl,
    input  logic                                  use_line,
    input  logic [rdwbc_pkg::DELAY_AW-1:0]        addr,
    input  logic signed [rdwbc_pkg::SAMPLE_W-1:0] sample,
    input  logic [rdwbc_pkg::MIX_W-1:0]           gain,
    input  logic signed [rdwbc_pkg::SAMPLE_W-1:0] wet,
    output logic signed [rdwbc_pkg::SAMPLE_W-1:0] result
);
    import rdwbc_pkg::*;

    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = MIX_W + 1 + DIFF_W;
    localparam int SUM_W  = PROD_W - 16;

    logic signed [SAMPLE_W-1:0] line_mem [MAX_DELAY];
    logic [MAX_DELAY-1:0]       line_valid_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;
    logic                       use_line_reg;
    logic signed [SAMPLE_W-1:0] direct_reg;
    logic signed [SAMPLE_W-1:0] dry_hold_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    logic signed [SAMPLE_W-1:0] dry;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [SUM_W-1:0]    sum;

    assign dry       = use_line_reg ? (rd_valid_reg ? rd_data_reg : '0) : direct_reg;
    assign diff      = DIFF_W'(wet) - DIFF_W'(dry);
    assign prod_next = $signed({1'b0, gain}) * diff;
    assign sum       = SUM_W'(dry_hold_reg) + prod_reg[PROD_W-1:16];
    assign result    = sum[SAMPLE_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.accept && use_line)
        begin
            line_mem[addr] <= sample;
            rd_data_reg    <= line_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            use_line_reg   <= 1'b0;
        end
        else if (ctl.accept)
        begin
            use_line_reg <= use_line;
            if (use_line)
            begin
                rd_valid_reg         <= line_valid_reg[addr];
                line_valid_reg[addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            direct_reg <= sample;
        end
        if (ctl.mul)
        begin
            prod_reg     <= prod_next;
            dry_hold_reg <= dry;
        end
    end

endmodule

// ----- rtl/ramped_dry_wet_bypass_crossfade_unit.sv -----
// Dry/wet crossfade with ramped footswitch and bypass mix levels and a delayed
// dry path. Each request goes through accept (ramp update, delay line read and
// write), gain multiply, per-lane blend multiply and result load, in that order.
// The next request is taken once the result is in the output register, so only
// one request is in flight at a time. Two lanes (left, right) each hold a
// 256-entry dry delay line whose unwritten entries read as zero; no clearing
// pass is needed after reset. Registers sit on an APB port at byte addresses
// 0, 4, 8, 12 and 16.
// depends on rdwbc_pkg, rdwbc_gain, rdwbc_lane
module ramped_dry_wet_bypass_crossfade_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rdwbc_pkg::rdwbc_in_t          in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rdwbc_pkg::rdwbc_out_t         out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdwbc_pkg::ADDR_W-1:0]  paddr,
    input  logic [rdwbc_pkg::DATA_W-1:0]  pwdata,
    output logic [rdwbc_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);
    import rdwbc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GAIN = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [1:0]          input_channels_reg;
    logic [1:0]          output_channels_reg;
    logic [LEN_W-1:0]    dry_delay_length_reg;
    logic [MIX_W-1:0]    switch_ramp_step_reg;
    logic [MIX_W-1:0]    bypass_ramp_step_reg;
    logic [DELAY_AW-1:0] line_pos_reg;
    logic signed [SAMPLE_W-1:0] mono_reg;
    logic signed [SAMPLE_W-1:0] wet_reg;
    rdwbc_out_t          out_data_reg;
    logic                out_valid_reg;

    logic                in_accept;
    logic                cfg_write;
    logic                out_free;
    logic                load;
    logic                stereo_in;
    logic                use_line;
    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    pos_inc;
    logic signed [SAMPLE_W-1:0] dry_right;
    logic signed [SAMPLE_W:0]   pair_sum;
    logic signed [SAMPLE_W-1:0] mono_next;
    logic [MIX_W-1:0]    gain;
    logic signed [SAMPLE_W-1:0] lane_left;
    logic signed [SAMPLE_W-1:0] lane_right;
    rdwbc_ctl_t          ctl;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load      = (state_reg == ST_LOAD) && out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    assign ctl.accept = in_accept;
    assign ctl.gain   = (state_reg == ST_GAIN);
    assign ctl.mul    = (state_reg == ST_MUL);

    assign stereo_in = input_channels_reg[1];
    assign len_eff   = (dry_delay_length_reg > MAX_LEN) ? MAX_LEN : dry_delay_length_reg;
    assign use_line  = (len_eff != '0);
    assign pos_inc   = LEN_W'(line_pos_reg) + LEN_W'(1);
    assign dry_right = stereo_in ? in_data.in_right : in_data.in_left;
    assign pair_sum  = (SAMPLE_W+1)'(in_data.in_left) + (SAMPLE_W+1)'(in_data.in_right);
    assign mono_next = stereo_in ? pair_sum[SAMPLE_W:1] : in_data.in_left;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN: state_next = ST_MUL;
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            line_pos_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_accept && use_line)
            begin
                line_pos_reg <= (pos_inc >= len_eff) ? '0 : pos_inc[DELAY_AW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mono_reg <= mono_next;
            wet_reg  <= in_data.wet_sample;
        end
        if (load)
        begin
            out_data_reg.out_left  <= lane_left;
            out_data_reg.out_right <= output_channels_reg[1] ? lane_right : '0;
            out_data_reg.mono_feed <= mono_reg;
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_channels_reg   <= 2'd2;
            output_channels_reg  <= 2'd2;
            dry_delay_length_reg <= '0;
            switch_ramp_step_reg <= MIX_W'(171);
            bypass_ramp_step_reg <= MIX_W'(273);
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_INPUT_CHANNELS:   input_channels_reg   <= pwdata[1:0];
                REG_OUTPUT_CHANNELS:  output_channels_reg  <= pwdata[1:0];
                REG_DRY_DELAY_LENGTH: dry_delay_length_reg <= pwdata[LEN_W-1:0];
                REG_SWITCH_RAMP_STEP: switch_ramp_step_reg <= pwdata[MIX_W-1:0];
                REG_BYPASS_RAMP_STEP: bypass_ramp_step_reg <= pwdata[MIX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_INPUT_CHANNELS:   prdata = DATA_W'(input_channels_reg);
            REG_OUTPUT_CHANNELS:  prdata = DATA_W'(output_channels_reg);
            REG_DRY_DELAY_LENGTH: prdata = DATA_W'(dry_delay_length_reg);
            REG_SWITCH_RAMP_STEP: prdata = DATA_W'(switch_ramp_step_reg);
            REG_BYPASS_RAMP_STEP: prdata = DATA_W'(bypass_ramp_step_reg);
            default:              prdata = '0;
        endcase
    end

    rdwbc_gain u_gain (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .switch_on   (in_data.switch_on),
        .bypass_on   (in_data.bypass_on),
        .switch_step (switch_ramp_step_reg),
        .bypass_step (bypass_ramp_step_reg),
        .gain        (gain)
    );

    rdwbc_lane u_lane_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .use_line (use_line),
        .addr     (line_pos_reg),
        .sample   (in_data.in_left),
        .gain     (gain),
        .wet      (wet_reg),
        .result   (lane_left)
    );

    rdwbc_lane u_lane_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .use_line (use_line),
        .addr     (line_pos_reg),
        .sample   (dry_right),
        .gain     (gain),
        .wet      (wet_reg),
        .result   (lane_right)
    );

`ifndef SYNTHESIS
    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_GAIN)
        else $error("request accepted without starting the gain stage");
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_LOAD)
        else $error("result raised outside the load stage");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(out_data_reg))
        else $error("held result overwritten");
`endif

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for ramped_dry_wet_bypass_crossfade_unit: directed table, then
// random requests over many register settings, checked against an in-bench crossfade model
// depends on rdwbc_pkg and the unit's rtl
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rdwbc_pkg::*;

    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int TARGET_ITEMS  = 1200;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'h7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'h800000;

    typedef struct {
        rdwbc_in_t  req;
        bit         typed;
        rdwbc_out_t want;
    } vector_row_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    rdwbc_in_t           in_data   = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    rdwbc_out_t          out_data;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // register mirror
    logic [1:0]          in_ch    = 2'd2;
    logic [1:0]          out_ch   = 2'd2;
    logic [LEN_W-1:0]    dly_len  = '0;
    logic [MIX_W-1:0]    sw_step  = MIX_W'(171);
    logic [MIX_W-1:0]    bp_step  = MIX_W'(273);

    // crossfade state
    logic [MIX_W-1:0]           sw_mix   = '0;
    logic [MIX_W-1:0]           bp_mix   = UNITY;
    logic signed [SAMPLE_W-1:0] line_l [MAX_DELAY] = '{default: '0};
    logic signed [SAMPLE_W-1:0] line_r [MAX_DELAY] = '{default: '0};
    int unsigned                line_pos = 0;

    rdwbc_out_t    pending_mix [$];
    vector_row_t   directed_rows [$];
    bit            row_typed = 1'b0;
    rdwbc_out_t    row_want  = '0;
    int            errors = 0;
    int            idle_cycles = 0;
    int            requests_sent = 0;
    int            burst_left = 0;
    bit            sw_target = 1'b0;
    bit            bp_target = 1'b1;
    bit            hold_wanted = 1'b0;
    bit            hold_done = 1'b0;
    int            stall_mode = 0;
    int            stall_left = 0;
    int            stall_tick = 0;

    ramped_dry_wet_bypass_crossfade_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [MIX_W-1:0] step_level(input logic [MIX_W-1:0] v,
                                                    input logic             on,
                                                    input logic [MIX_W-1:0] step);
        int cur;
        int tgt;
        int st;
        cur = v;
        tgt = on ? 65536 : 0;
        st  = step;
        if (cur < tgt)
        begin
            cur = (tgt - cur > st) ? cur + st : tgt;
        end
        else if (cur > tgt)
        begin
            cur = (cur - tgt > st) ? cur - st : tgt;
        end
        return MIX_W'(cur);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] weigh(input longint gain,
                                                         input longint wet,
                                                         input longint dry);
        return SAMPLE_W'((gain * wet + (longint'(UNITY) - gain) * dry) >>> 16);
    endfunction

    function automatic rdwbc_out_t compute_mix(input rdwbc_in_t r);
        rdwbc_out_t  o;
        longint      lft;
        longint      rgt;
        longint      wet;
        longint      dry_l;
        longint      dry_r;
        longint      gain;
        int unsigned len;
        int unsigned p;
        bit          stereo_in;
        stereo_in = (in_ch >= 2'd2);
        len = (dly_len > MAX_DELAY) ? MAX_DELAY : dly_len;
        lft = longint'($signed(r.in_left));
        rgt = stereo_in ? longint'($signed(r.in_right)) : lft;
        wet = longint'($signed(r.wet_sample));
        o.mono_feed = stereo_in ? SAMPLE_W'((lft + rgt) >>> 1) : SAMPLE_W'(lft);
        sw_mix = step_level(sw_mix, r.switch_on, sw_step);
        bp_mix = step_level(bp_mix, r.bypass_on, bp_step);
        gain = (longint'(sw_mix) * (longint'(UNITY) - longint'(bp_mix))) >>> 16;
        dry_l = lft;
        dry_r = rgt;
        if (len != 0)
        begin
            p = line_pos % MAX_DELAY;
            dry_l = longint'(line_l[p]);
            dry_r = longint'(line_r[p]);
            line_l[p] = SAMPLE_W'(lft);
            line_r[p] = SAMPLE_W'(rgt);
            line_pos = (p + 1 >= len) ? 0 : p + 1;
        end
        o.out_left  = weigh(gain, wet, dry_l);
        o.out_right = (out_ch >= 2'd2) ? weigh(gain, wet, dry_r) : '0;
        return o;
    endfunction

    task automatic report(input string field, input logic signed [SAMPLE_W-1:0] want,
                          input logic signed [SAMPLE_W-1:0] got);
        $display("%0t %s expected %0d got %0d", $time, field, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin : monitor
        rdwbc_out_t want;
        bit         busy;
        if (rst_n)
        begin
            busy = psel;
            if (in_valid && !in_stall)
            begin
                want = compute_mix(in_data);
                pending_mix.push_back(row_typed ? row_want : want);
                busy = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                if (pending_mix.size() == 0)
                begin
                    $display("%0t result with none expected: %h", $time, out_data);
                    errors++;
                end
                else
                begin
                    want = pending_mix.pop_front();
                    if (out_data.out_left !== want.out_left)
                        report("out_left", want.out_left, out_data.out_left);
                    if (out_data.out_right !== want.out_right)
                        report("out_right", want.out_right, out_data.out_right);
                    if (out_data.mono_feed !== want.mono_feed)
                        report("mono_feed", want.mono_feed, out_data.mono_feed);
                end
            end
            idle_cycles = busy ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t no progress for %0d cycles", $time, IDLE_LIMIT);
                $display("ramped_dry_wet_bypass_crossfade_unit: mismatch");
                $finish;
            end
        end
    end

    always
    begin : receiver
        @(negedge clk);
        if (hold_wanted && !hold_done)
        begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_done = 1'b1;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (stall_tick % 5 < 2);
            endcase
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_INPUT_CHANNELS:   in_ch   = value[1:0];
            REG_OUTPUT_CHANNELS:  out_ch  = value[1:0];
            REG_DRY_DELAY_LENGTH: dly_len = value[LEN_W-1:0];
            REG_SWITCH_RAMP_STEP: sw_step = value[MIX_W-1:0];
            REG_BYPASS_RAMP_STEP: bp_step = value[MIX_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_request(input rdwbc_in_t r, input bit typed, input rdwbc_out_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        in_data   <= r;
        row_typed <= typed;
        row_want  <= want;
        do @(posedge clk); while (in_stall);
        requests_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_mix.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_step();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 1;
            2: return 65536;
            3: return 131071;
            4: return $urandom_range(1, 65535);
            default: return $urandom_range(500, 20000);
        endcase
    endfunction

    task automatic run_phase(input logic [DATA_W-1:0] ic, input logic [DATA_W-1:0] oc,
                             input logic [DATA_W-1:0] dl, input logic [DATA_W-1:0] ss,
                             input logic [DATA_W-1:0] bs, input int n, input int flip_odds);
        rdwbc_in_t r;
        write_reg(REG_INPUT_CHANNELS, ic);
        write_reg(REG_OUTPUT_CHANNELS, oc);
        write_reg(REG_DRY_DELAY_LENGTH, dl);
        write_reg(REG_SWITCH_RAMP_STEP, ss);
        write_reg(REG_BYPASS_RAMP_STEP, bs);
        repeat (n)
        begin
            if ($urandom_range(1, flip_odds) == 1)
                sw_target = !sw_target;
            if ($urandom_range(1, flip_odds) == 1)
                bp_target = !bp_target;
            r.in_left    = random_sample();
            r.in_right   = random_sample();
            r.wet_sample = random_sample();
            r.switch_on  = sw_target;
            r.bypass_on  = bp_target;
            send_request(r, 1'b0, '0);
        end
        drain();
    endtask

    function automatic void add_vector(input logic signed [SAMPLE_W-1:0] l,
                                       input logic signed [SAMPLE_W-1:0] rt,
                                       input logic signed [SAMPLE_W-1:0] w,
                                       input logic sw, input logic bp, input bit typed,
                                       input logic signed [SAMPLE_W-1:0] want_l,
                                       input logic signed [SAMPLE_W-1:0] want_r,
                                       input logic signed [SAMPLE_W-1:0] want_m);
        vector_row_t v;
        v.req.in_left    = l;
        v.req.in_right   = rt;
        v.req.wet_sample = w;
        v.req.switch_on  = sw;
        v.req.bypass_on  = bp;
        v.typed          = typed;
        v.want.out_left  = want_l;
        v.want.out_right = want_r;
        v.want.mono_feed = want_m;
        directed_rows.push_back(v);
    endfunction

    initial
    begin : stimulus
        int odds;
        // fully bypassed after reset: outputs are the dry inputs
        add_vector(0, 0, 0, 1'b0, 1'b1, 1'b1, 0, 0, 0);
        add_vector(S_MAX, S_MAX, S_MIN, 1'b1, 1'b1, 1'b1, S_MAX, S_MAX, S_MAX);
        add_vector(S_MIN, S_MIN, S_MAX, 1'b1, 1'b1, 1'b1, S_MIN, S_MIN, S_MIN);
        add_vector(S_MAX, S_MIN, 0, 1'b0, 1'b1, 1'b1, S_MAX, S_MIN, -1);
        add_vector(-1, 0, 123, 1'b1, 1'b1, 1'b1, -1, 0, -1);
        add_vector(1, 0, -77, 1'b1, 1'b1, 1'b1, 1, 0, 0);
        add_vector(3, -6, S_MAX, 1'b0, 1'b1, 1'b1, 3, -6, -2);
        // bypass released, wet starts fading in
        add_vector(S_MAX, S_MIN, S_MAX, 1'b1, 1'b0, 1'b0, 0, 0, 0);
        add_vector(S_MIN, S_MAX, S_MIN, 1'b1, 1'b0, 1'b0, 0, 0, 0);
        add_vector(0, 0, S_MAX, 1'b1, 1'b0, 1'b0, 0, 0, 0);
        add_vector(S_MAX, S_MAX, S_MIN, 1'b0, 1'b0, 1'b0, 0, 0, 0);
        add_vector(S_MIN, S_MIN, S_MAX, 1'b1, 1'b0, 1'b0, 0, 0, 0);
        add_vector(24'h123456, -654321, -1, 1'b0, 1'b1, 1'b0, 0, 0, 0);
        add_vector(-1, -1, -1, 1'b1, 1'b0, 1'b0, 0, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
        drain();

        // instant switching, undelayed dry
        run_phase(2, 2, 0, 65536, 65536, 60, 8);
        // mono in, one output, short delay
        run_phase(1, 1, 5, 171, 273, 120, 40);
        // channel counts of 0 and 3, full-length delay, long output hold-off
        hold_wanted = 1'b1;
        run_phase(0, 3, MAX_DELAY, 1000, 4000, 300, 60);
        // delay shortened below the line position, ramps frozen
        run_phase(3, 0, 8, 0, 0, 80, 4);
        // delay beyond the line size, switch step past full scale
        run_phase(2, 2, 511, 131071, 1, 100, 30);
        run_phase(2, 1, 1, 2000, 65535, 80, 20);

        while (requests_sent < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: odds = 2;
                1: odds = 20;
                default: odds = 80;
            endcase
            run_phase($urandom_range(0, 3), $urandom_range(0, 3),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 12),
                      random_step(), random_step(), $urandom_range(40, 160), odds);
        end

        while (pending_mix.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("ramped_dry_wet_bypass_crossfade_unit: match");
        else
            $display("ramped_dry_wet_bypass_crossfade_unit: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rdwbc_pkg.sv
rtl/rdwbc_gain.sv
rtl/rdwbc_lane.sv
rtl/ramped_dry_wet_bypass_crossfade_unit.sv
tb/tb_top.sv
